// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the sliding window maximum core.
// Clocked, reset-qualified concurrent assertions that report through $error.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: explicit clock and reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Usual form inside a module that has ports named clock and reset.
`define ASSERT_SYNC(lbl, prop, msg) `ASSERT_CLK(lbl, clock, reset, prop, msg)

`endif

// ===== rtl/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg
// Types and constants of the sliding window maximum core.
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

   localparam int unsigned MAX_WINDOW = 256;
   localparam int unsigned IDX_W      = $clog2(MAX_WINDOW);
   localparam int unsigned CNT_W      = $clog2(MAX_WINDOW + 1);
   localparam int unsigned VALUE_W    = 32;
   localparam int unsigned POS_W      = 16;
   localparam int unsigned WSIZE_W    = 9;
   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [WSIZE_W-1:0]    WSIZE_RESET          = WSIZE_W'(1);
   localparam logic [CSR_ADDR_W-1:0] CSR_WINDOW_SIZE_ADDR = '0;

   typedef struct packed {
      logic signed [VALUE_W-1:0] sample;
      logic                      start_of_array;
   } swm_req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] window_max;
      logic [POS_W-1:0]          window_start;
   } swm_rsp_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [POS_W-1:0]          position;
   } swm_entry_type;

endpackage

`default_nettype wire

// ===== rtl/sliding_window_maximum_core.sv =====
// ----------------------------------------------------------------------------
// sliding_window_maximum_core
// Running maximum over the last window_size signed samples, kept as a
// monotonic deque of (value, position) pairs in a single ring memory.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Payload
//  req       in         req_valid / req_stall  swm_req_type (sample, start flag)
//  rsp       out        rsp_valid / rsp_stall  swm_rsp_type (maximum, window start)
//  csr       in/out     APB, pready always 1   window_size at byte address 0
//
//  A request goes straight to the push state when the deque is empty or the
//  start flag is set. Otherwise it pops smaller entries from the back and,
//  unless that empties the deque, then expired entries from the front,
//  before the push; each pop is one read of the ring memory, whose read
//  data arrive in the cycle after the address.
//  Every sample is pushed once and popped at most once. The result register
//  lets a new request in while a result is still stalled; a second result
//  waits in hold until the first is taken.
//  Reset empties the deque and sets window_size to 1; the memory is not
//  cleared, since only live entries are ever used.
//
`default_nettype none
`include "assert_macros.svh"

module sliding_window_maximum_core (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire swm_pkg::swm_req_type          req_data,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output swm_pkg::swm_rsp_type               rsp_data,
   input  wire                                psel,
   input  wire                                penable,
   input  wire                                pwrite,
   input  wire [swm_pkg::CSR_ADDR_W-1:0]      paddr,
   input  wire [swm_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [swm_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);
   import swm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BACK,
      ST_FRONT,
      ST_PUSH,
      ST_HOLD
   } state_type;

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
      logic [IDX_W-1:0] r;
      r = (32'(i) + 32'd1 >= MAX_WINDOW) ? '0 : i + IDX_W'(1);
      return r;
   endfunction

   function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
      logic [IDX_W-1:0] r;
      r = (i == '0) ? IDX_W'(MAX_WINDOW - 1) : i - IDX_W'(1);
      return r;
   endfunction

   // Window size zero behaves as one, sizes beyond the ring saturate.
   function automatic logic [CNT_W-1:0] eff_window(input logic [WSIZE_W-1:0] w);
      logic [CNT_W-1:0] r;
      if (w == '0) begin
         r = CNT_W'(1);
      end else if (32'(w) > MAX_WINDOW) begin
         r = CNT_W'(MAX_WINDOW);
      end else begin
         r = CNT_W'(w);
      end
      return r;
   endfunction

   state_type                 state_ff, state_in;
   logic [IDX_W-1:0]          head_ff, head_in;
   logic [IDX_W-1:0]          tail_ff, tail_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [POS_W-1:0]          spos_ff, spos_in;
   logic                      filled_ff, filled_in;
   logic [WSIZE_W-1:0]        wsize_ff, wsize_in;
   logic signed [VALUE_W-1:0] val_ff, val_in;
   logic [POS_W-1:0]          pos_ff, pos_in;
   logic [CNT_W-1:0]          k_ff, k_in;
   logic signed [VALUE_W-1:0] front_ff, front_in;
   logic [POS_W-1:0]          wstart_ff, wstart_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   swm_rsp_type               rsp_data_ff, rsp_data_in;

   swm_entry_type             ring_mem [MAX_WINDOW];
   swm_entry_type             rd_data_ff;
   logic [IDX_W-1:0]          rd_addr;
   logic                      wr_en;
   swm_entry_type             wr_entry;

   logic                      out_free;
   logic                      filled_now;
   logic [POS_W-1:0]          front_dist;
   logic [POS_W-1:0]          wstart_now;
   logic                      pop_state;
   logic                      rsp_state;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pready    = 1'b1;
   assign prdata    = (paddr == CSR_WINDOW_SIZE_ADDR) ? CSR_DATA_W'(wsize_ff) : '0;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign front_dist = pos_ff - rd_data_ff.position;
   assign filled_now = filled_ff || (32'(pos_ff) >= 32'(k_ff) - 32'd1);
   assign wstart_now = pos_ff + POS_W'(1) - POS_W'(k_ff);
   assign wr_entry   = '{value: val_ff, position: pos_ff};
   assign pop_state  = (state_ff == ST_BACK) || (state_ff == ST_FRONT);
   assign rsp_state  = (state_ff == ST_PUSH) || (state_ff == ST_HOLD);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      spos_in      = spos_ff;
      filled_in    = filled_ff;
      wsize_in     = wsize_ff;
      val_in       = val_ff;
      pos_in       = pos_ff;
      k_in         = k_ff;
      front_in     = front_ff;
      wstart_in    = wstart_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rd_addr      = head_ff;
      wr_en        = 1'b0;

      if (psel && penable && pwrite && (paddr == CSR_WINDOW_SIZE_ADDR)) begin
         wsize_in = pwdata[WSIZE_W-1:0];
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            // Fetch the back entry now so that it is ready in the next cycle.
            rd_addr = ring_prev(tail_ff);
            if (req_valid) begin
               val_in   = req_data.sample;
               k_in     = eff_window(wsize_ff);
               front_in = req_data.sample;
               if (req_data.start_of_array) begin
                  head_in   = '0;
                  tail_in   = '0;
                  count_in  = '0;
                  pos_in    = '0;
                  filled_in = 1'b0;
                  state_in  = ST_PUSH;
               end else begin
                  pos_in   = spos_ff;
                  state_in = (count_ff != '0) ? ST_BACK : ST_PUSH;
               end
            end
         end
         ST_BACK: begin
            if (rd_data_ff.value < val_ff) begin
               tail_in  = ring_prev(tail_ff);
               count_in = count_ff - CNT_W'(1);
               if (count_ff == CNT_W'(1)) begin
                  front_in = val_ff;
                  state_in = ST_PUSH;
               end else begin
                  rd_addr = ring_prev(ring_prev(tail_ff));
               end
            end else begin
               rd_addr  = head_ff;
               state_in = ST_FRONT;
            end
         end
         ST_FRONT: begin
            if (32'(front_dist) >= 32'(k_ff)) begin
               head_in  = ring_next(head_ff);
               count_in = count_ff - CNT_W'(1);
               if (count_ff == CNT_W'(1)) begin
                  front_in = val_ff;
                  state_in = ST_PUSH;
               end else begin
                  rd_addr = ring_next(head_ff);
               end
            end else begin
               front_in = rd_data_ff.value;
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (32'(count_ff) < MAX_WINDOW) begin
               wr_en    = 1'b1;
               tail_in  = ring_next(tail_ff);
               count_in = count_ff + CNT_W'(1);
            end
            filled_in = filled_now;
            spos_in   = pos_ff + POS_W'(1);
            wstart_in = wstart_now;
            if (!filled_now) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{window_max: front_ff, window_start: wstart_now};
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{window_max: front_ff, window_start: wstart_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         spos_ff      <= '0;
         filled_ff    <= 1'b0;
         wsize_ff     <= WSIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         spos_ff      <= spos_in;
         filled_ff    <= filled_in;
         wsize_ff     <= wsize_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      val_ff      <= val_in;
      pos_ff      <= pos_in;
      k_ff        <= k_in;
      front_ff    <= front_in;
      wstart_ff   <= wstart_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Ring memory: one write port, one registered read port. A write only
   // happens in the push state.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[tail_ff] <= wr_entry;
      end
      rd_data_ff <= ring_mem[rd_addr];
   end

   `ASSERT_SYNC(a_count_bound, (32'(count_ff) <= MAX_WINDOW), "count beyond ring size")
   `ASSERT_SYNC(a_empty_ring, (count_ff == '0) |-> (head_ff == tail_ff), "head and tail apart")
   `ASSERT_SYNC(a_pop_nonempty, pop_state |-> (count_ff != '0), "pop on an empty deque")
   `ASSERT_SYNC(a_rsp_source, $rose(rsp_valid_ff) |-> $past(rsp_state), "result from wrong state")

endmodule

`default_nettype wire

// ===== bench/sliding_window_maximum_core_test.sv =====
// ----------------------------------------------------------------------------
// sliding_window_maximum_core_test
// Self-checking bench for the sliding window maximum core. Requests are
// driven from a queue with random gaps and result stalls, each accepted
// request is run through a deque predictor in the bench, and every result
// is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sliding_window_maximum_core_test;

   import swm_pkg::*;

   // One request may pop a full deque, so allow well over that before a change.
   localparam int DRAIN_CYCLES   = 2 * MAX_WINDOW + 16;
   localparam int LONG_HOLD      = 400;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef enum int unsigned {
      STYLE_WIDE,
      STYLE_PINNED,
      STYLE_NARROW,
      STYLE_RISING,
      STYLE_FALLING
   } sample_style_type;

   logic                  clock;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_stall;
   swm_req_type           req_data       = '0;
   logic                  rsp_valid;
   logic                  rsp_stall      = 1'b0;
   swm_rsp_type           rsp_data;
   logic                  psel           = 1'b0;
   logic                  penable        = 1'b0;
   logic                  pwrite         = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr          = '0;
   logic [CSR_DATA_W-1:0] pwdata         = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // Predictor state.
   swm_entry_type         max_candidates[$];
   logic [POS_W-1:0]      next_position  = '0;
   logic                  window_full    = 1'b0;
   logic [WSIZE_W-1:0]    window_size_reg = WSIZE_RESET;
   swm_rsp_type           expected_maxima[$];
   swm_rsp_type           oldest_max;

   swm_req_type           pending_requests[$];
   int unsigned           requests_queued   = 0;
   int unsigned           requests_accepted = 0;
   logic                  req_taken         = 1'b0;
   int unsigned           send_idle_pct     = 0;
   int unsigned           rsp_stall_pct     = 0;
   logic                  long_hold_request = 1'b0;
   int unsigned           hold_left         = 0;
   int unsigned           quiet_cycles      = 0;
   int unsigned           error_count       = 0;

   sample_style_type          run_style   = STYLE_WIDE;
   int unsigned               run_left    = 0;
   logic signed [VALUE_W-1:0] last_sample = '0;

   sliding_window_maximum_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic predict_window_max(input swm_req_type item);
      int unsigned      span;
      logic [POS_W-1:0] position;
      logic [POS_W-1:0] age;
      swm_entry_type    entry;
      swm_rsp_type      result;
      if (window_size_reg == 0) begin
         span = 1;
      end else if (window_size_reg > MAX_WINDOW) begin
         span = MAX_WINDOW;
      end else begin
         span = window_size_reg;
      end
      if (item.start_of_array) begin
         max_candidates.delete();
         next_position = '0;
         window_full   = 1'b0;
      end
      position = next_position;
      while (max_candidates.size() > 0 && item.sample > max_candidates[$].value)
         max_candidates.delete(max_candidates.size() - 1);
      // Ages are taken modulo the position width, so a wrapped position is harmless.
      while (max_candidates.size() > 0) begin
         age = position - max_candidates[0].position;
         if (age < span)
            break;
         max_candidates.delete(0);
      end
      if (max_candidates.size() < MAX_WINDOW) begin
         entry.value    = item.sample;
         entry.position = position;
         max_candidates.insert(max_candidates.size(), entry);
      end
      if (position >= span - 1)
         window_full = 1'b1;
      next_position = position + 1'b1;
      if (window_full) begin
         result.window_max   = max_candidates[0].value;
         result.window_start = position - POS_W'(span - 1);
         expected_maxima.insert(expected_maxima.size(), result);
      end
   endtask

   // Request driver: a request stays on the bus until it has been taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         req_taken = 1'b0;
         if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data  <= pending_requests[0];
            req_valid <= 1'b1;
            pending_requests.delete(0);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result stall, with a long hold-off on request so that the core backs up.
   always @(negedge clock) begin
      if (long_hold_request) begin
         hold_left         = LONG_HOLD;
         long_hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_maxima.size() == 0) begin
               $error("window_max: no result expected, got %0d (window_start %0d)",
                      rsp_data.window_max, rsp_data.window_start);
               error_count++;
            end else begin
               oldest_max = expected_maxima[0];
               expected_maxima.delete(0);
               if (rsp_data.window_max !== oldest_max.window_max) begin
                  $error("window_max: expected %0d, got %0d",
                         oldest_max.window_max, rsp_data.window_max);
                  error_count++;
               end
               if (rsp_data.window_start !== oldest_max.window_start) begin
                  $error("window_start: expected %0d, got %0d",
                         oldest_max.window_start, rsp_data.window_start);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            predict_window_max(req_data);
            requests_accepted++;
            req_taken = 1'b1;
         end
      end
   end

   // Quiet stretches are bounded by the hold-off, a full deque pop and the drain pauses.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (psel && penable && pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic wait_until_idle();
      while (requests_accepted != requests_queued || expected_maxima.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes window_size once the core is idle, reads it back and sets the request idling and result stall rates.
   task automatic start_phase(input logic [CSR_DATA_W-1:0] size,
                              input int unsigned send_pct, input int unsigned stall_pct);
      wait_until_idle();
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_WINDOW_SIZE_ADDR;
      pwdata  <= size;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      window_size_reg = size[WSIZE_W-1:0];
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[WSIZE_W-1:0] !== size[WSIZE_W-1:0]) begin
         $error("window_size: expected %0d, got %0d", size[WSIZE_W-1:0],
                prdata[WSIZE_W-1:0]);
         error_count++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
   endtask

   task automatic queue_request(input logic signed [VALUE_W-1:0] value, input logic start);
      swm_req_type item;
      item.sample         = value;
      item.start_of_array = start;
      pending_requests.insert(pending_requests.size(), item);
      requests_queued++;
   endtask

   // Samples come in runs of one shape, so that the deque grows deep and then collapses.
   task automatic next_sample(output logic signed [VALUE_W-1:0] value);
      if (run_left == 0) begin
         run_style = sample_style_type'($urandom_range(4));
         run_left  = $urandom_range(64, 1);
      end
      run_left--;
      case (run_style)
         STYLE_PINNED: begin
            case ($urandom_range(3))
               0:       value = 32'sh7FFF_FFFF;
               1:       value = 32'sh8000_0000;
               2:       value = '0;
               default: value = '1;
            endcase
         end
         STYLE_NARROW:  value = 32'($urandom_range(8)) - 32'd4;
         STYLE_RISING:  value = last_sample + 32'($urandom_range(5));
         STYLE_FALLING: value = last_sample - 32'($urandom_range(5));
         default:       value = $urandom;
      endcase
      last_sample = value;
   endtask

   task automatic queue_random_requests(input int unsigned count,
                                        input int unsigned start_one_in,
                                        input logic start_first);
      logic signed [VALUE_W-1:0] value;
      logic                      start;
      for (int unsigned i = 0; i < count; i++) begin
         next_sample(value);
         if (i == 0)
            start = start_first;
         else
            start = (start_one_in != 0) && ($urandom_range(start_one_in - 1) == 0);
         queue_request(value, start);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: extremes, equal values, rising and falling runs, a restart.
      start_phase(3, 0, 0);
      queue_request(0, 1'b1);
      queue_request(32'sh7FFF_FFFF, 1'b0);
      queue_request(32'sh8000_0000, 1'b0);
      queue_request(-1, 1'b0);
      queue_request(1, 1'b0);
      queue_request(5, 1'b0);
      queue_request(5, 1'b0);
      queue_request(5, 1'b0);
      queue_request(10, 1'b0);
      queue_request(20, 1'b0);
      queue_request(30, 1'b0);
      queue_request(30, 1'b0);
      queue_request(20, 1'b0);
      queue_request(10, 1'b0);
      queue_request(32'sh8000_0000, 1'b1);
      queue_request(32'sh8000_0000, 1'b0);
      queue_request(32'sh8000_0000, 1'b0);
      queue_request(32'sh7FFF_FFFF, 1'b0);
      queue_request(-5, 1'b0);
      queue_request(100, 1'b0);
      queue_request(-100, 1'b0);
      queue_request(-100, 1'b0);

      start_phase(1, 0, 0);
      queue_random_requests(100, 25, 1'b1);

      // A size of zero behaves as one.
      start_phase(0, 82, 0);
      queue_random_requests(60, 20, 1'b1);

      start_phase(7, 0, 82);
      long_hold_request = 1'b1;
      queue_random_requests(120, 40, 1'b1);

      // Larger window mid-array: results cover windows only partly filled.
      start_phase(20, 6, 6);
      queue_random_requests(120, 0, 1'b0);

      // Smaller window mid-array: older candidates must go.
      start_phase(5, 82, 0);
      queue_random_requests(100, 30, 1'b0);

      start_phase(MAX_WINDOW, 0, 82);
      queue_random_requests(280, 0, 1'b1);

      // Above the maximum the size saturates; the array carries on.
      start_phase(511, 6, 6);
      queue_random_requests(120, 0, 1'b0);

      start_phase(13, 0, 0);
      queue_random_requests(30, 15, 1'b1);

      wait_until_idle();
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/swm_pkg.sv
rtl/sliding_window_maximum_core.sv
bench/sliding_window_maximum_core_test.sv
